[hw/rtl/lsi_pkg.sv]
// Shared widths, payload types and codes of the line segment intersection unit.
`timescale 1ns / 1ps

package lsi_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_BITS   = 48;

    // Line coefficients and their products.
    localparam int AB_W  = COORD_BITS + 1;
    localparam int PC_W  = 2 * COORD_BITS + 1;
    localparam int C_W   = 2 * COORD_BITS + 2;
    localparam int DP_W  = 2 * AB_W;
    localparam int DET_W = 2 * AB_W + 1;
    localparam int NP_W  = AB_W + C_W;
    localparam int NUM_W = NP_W + 1;
    localparam int QW    = NUM_W + FRAC_BITS;

    // Bounding box test.
    localparam int SC_W  = COORD_BITS + FRAC_BITS;
    localparam int U_W   = OUT_BITS + 1;
    localparam int TOL_W = 32;
    localparam int THR_W = 16;

    // Configuration port.
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'd1;

    // Result status codes.
    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_PARALLEL = 2'd1;
    localparam logic [1:0] ST_OUTSIDE  = 2'd2;

    typedef struct packed {
        logic                         cmd;
        logic signed [COORD_BITS-1:0] first_start_x;
        logic signed [COORD_BITS-1:0] first_start_y;
        logic signed [COORD_BITS-1:0] first_end_x;
        logic signed [COORD_BITS-1:0] first_end_y;
        logic signed [COORD_BITS-1:0] second_start_x;
        logic signed [COORD_BITS-1:0] second_start_y;
        logic signed [COORD_BITS-1:0] second_end_x;
        logic signed [COORD_BITS-1:0] second_end_y;
    } t_lsi_in;

    typedef struct packed {
        logic [1:0]                 status;
        logic signed [OUT_BITS-1:0] cross_x;
        logic signed [OUT_BITS-1:0] cross_y;
        logic                       saturated;
    } t_lsi_out;

endpackage

[hw/rtl/line_segment_intersection.sv]
// Top level of the line segment intersection unit: a fully pipelined datapath.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake             Payload
//  input     in         i_valid / o_stall     i_data   (t_lsi_in)
//  output    out        o_valid / i_stall     o_data   (t_lsi_out)
//  config    in         i_cfg_we              i_cfg_idx, i_cfg_data
//
//  One item is accepted per cycle while o_stall is low. Most of the pipeline is the
//  restoring divider, which retires one quotient bit per stage over the 68 bits of
//  the scaled numerator.
//  Reset is synchronous and active low; it empties the pipeline and loads both
//  registers with 1.
//  A stall on the output holds the whole pipeline once the skid register is full;
//  o_stall is the skid register's valid bit, so it never depends on i_stall.

module line_segment_intersection
    import lsi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_lsi_in              i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_lsi_out             o_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // Side information that travels along with the divider.
    typedef struct packed {
        t_lsi_in            pt;
        logic               par;
        logic [DET_W-1:0]   dmag;
        logic               negx;
        logic               negy;
    } t_side;

    // Classification of one axis of one bounding box test.
    typedef struct packed {
        logic             zero;
        logic             opp;
        logic             big;
        logic [TOL_W-1:0] mu;
        logic [TOL_W-1:0] mv;
    } t_box;

    typedef struct packed {
        logic             zero;
        logic             opp;
        logic             big;
        logic [2*TOL_W-1:0] prod;
    } t_boxp;

    // Configuration registers.
    logic [THR_W-1:0] r_thr;
    logic [TOL_W-1:0] r_tol;

    // The pipeline moves as a whole whenever the skid register is empty.
    logic adv;
    logic r_skid_v;
    logic r_out_v;
    t_lsi_out r_skid;
    t_lsi_out r_out;

    // Stage A: line coefficients A and B.
    logic                   r_va;
    t_lsi_in                r_a_pt;
    logic signed [AB_W-1:0] r_a_a1, r_a_b1, r_a_a2, r_a_b2;

    // Stage B: products for C and for the determinant.
    logic                   r_vb;
    t_lsi_in                r_b_pt;
    logic signed [AB_W-1:0] r_b_a1, r_b_b1, r_b_a2, r_b_b2;
    logic signed [PC_W-1:0] r_b_c1a, r_b_c1b, r_b_c2a, r_b_c2b;
    logic signed [DP_W-1:0] r_b_d1, r_b_d2;

    // Stage C: C of both lines and the determinant.
    logic                    r_vc;
    t_lsi_in                 r_c_pt;
    logic signed [AB_W-1:0]  r_c_a1, r_c_b1, r_c_a2, r_c_b2;
    logic signed [C_W-1:0]   r_c_c1, r_c_c2;
    logic signed [DET_W-1:0] r_c_det;

    // Stage D: numerator products, determinant magnitude and parallel check.
    logic                   r_vd;
    t_lsi_in                r_d_pt;
    logic signed [NP_W-1:0] r_d_nx1, r_d_nx2, r_d_ny1, r_d_ny2;
    logic                   r_d_detneg;
    logic [DET_W-1:0]       r_d_dmag;
    logic                   r_d_par;

    // Stage E: signed numerators.
    logic                    r_ve;
    t_lsi_in                 r_e_pt;
    logic signed [NUM_W-1:0] r_e_numx, r_e_numy;
    logic                    r_e_detneg;
    logic [DET_W-1:0]        r_e_dmag;
    logic                    r_e_par;

    // Divider stages: each holds the partial remainder and a word that shifts
    // the dividend out at the top while quotient bits enter at the bottom.
    logic             r_dv   [0:QW];
    t_side            r_ds   [0:QW];
    logic [DET_W-1:0] r_xrem [0:QW];
    logic [QW-1:0]    r_xw   [0:QW];
    logic [DET_W-1:0] r_yrem [0:QW];
    logic [QW-1:0]    r_yw   [0:QW];

    // Stage F: signed and saturated coordinates.
    logic                       r_vf;
    t_lsi_in                    r_f_pt;
    logic                       r_f_par;
    logic signed [OUT_BITS-1:0] r_f_x, r_f_y;
    logic                       r_f_sat;

    // Stage G: box test differences, classified.
    logic                       r_vg;
    logic                       r_g_cmd;
    logic                       r_g_par;
    logic signed [OUT_BITS-1:0] r_g_x, r_g_y;
    logic                       r_g_sat;
    t_box                       r_g_box [0:3];

    // Stage H: products of the box test.
    logic                       r_vh;
    logic                       r_h_cmd;
    logic                       r_h_par;
    logic signed [OUT_BITS-1:0] r_h_x, r_h_y;
    logic                       r_h_sat;
    t_boxp                      r_h_box [0:3];

    function automatic t_box box_class(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b,
        input logic signed [OUT_BITS-1:0]   p
    );
        logic signed [SC_W-1:0] sa;
        logic signed [SC_W-1:0] sb;
        logic signed [U_W-1:0]  u;
        logic signed [U_W-1:0]  v;
        logic [U_W-1:0]         au;
        logic [U_W-1:0]         av;
        t_box                   res;
        sa = {a, {FRAC_BITS{1'b0}}};
        sb = {b, {FRAC_BITS{1'b0}}};
        u  = U_W'(sa) - U_W'(p);
        v  = U_W'(p) - U_W'(sb);
        au = u[U_W-1] ? U_W'(-u) : U_W'(u);
        av = v[U_W-1] ? U_W'(-v) : U_W'(v);
        res.zero = (u == '0) || (v == '0);
        res.opp  = u[U_W-1] ^ v[U_W-1];
        res.big  = (|au[U_W-1:TOL_W]) || (|av[U_W-1:TOL_W]);
        res.mu   = au[TOL_W-1:0];
        res.mv   = av[TOL_W-1:0];
        return res;
    endfunction

    // (a - p) * (p - b) + tolerance > 0, decided from the classification:
    // a product of equal signs is positive, a zero product leaves the tolerance,
    // and a negative product must stay below the tolerance in magnitude.
    function automatic logic box_pass(input t_boxp bx, input logic [TOL_W-1:0] tol);
        logic ok;
        if (bx.zero) begin
            ok = (tol != '0);
        end else if (!bx.opp) begin
            ok = 1'b1;
        end else begin
            ok = !bx.big && (bx.prod < {{TOL_W{1'b0}}, tol});
        end
        return ok;
    endfunction

    assign adv     = !r_skid_v;
    assign o_stall = r_skid_v;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_W'(1);
            r_tol <= TOL_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THRESHOLD: r_thr <= i_cfg_data[THR_W-1:0];
                CFG_TOLERANCE: r_tol <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Valid bits of the front stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else if (adv) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_ve <= r_vd;
        end
    end

    // Front stages: coefficients, C, determinant and numerators.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_pt <= i_data;
            r_a_a1 <= AB_W'($signed(i_data.first_end_y)) - AB_W'($signed(i_data.first_start_y));
            r_a_b1 <= AB_W'($signed(i_data.first_start_x)) - AB_W'($signed(i_data.first_end_x));
            r_a_a2 <= AB_W'($signed(i_data.second_end_y))
                      - AB_W'($signed(i_data.second_start_y));
            r_a_b2 <= AB_W'($signed(i_data.second_start_x))
                      - AB_W'($signed(i_data.second_end_x));

            r_b_pt  <= r_a_pt;
            r_b_a1  <= r_a_a1;
            r_b_b1  <= r_a_b1;
            r_b_a2  <= r_a_a2;
            r_b_b2  <= r_a_b2;
            r_b_c1a <= PC_W'(r_a_a1) * PC_W'($signed(r_a_pt.first_start_x));
            r_b_c1b <= PC_W'(r_a_b1) * PC_W'($signed(r_a_pt.first_start_y));
            r_b_c2a <= PC_W'(r_a_a2) * PC_W'($signed(r_a_pt.second_start_x));
            r_b_c2b <= PC_W'(r_a_b2) * PC_W'($signed(r_a_pt.second_start_y));
            r_b_d1  <= DP_W'(r_a_a1) * DP_W'(r_a_b2);
            r_b_d2  <= DP_W'(r_a_a2) * DP_W'(r_a_b1);

            r_c_pt  <= r_b_pt;
            r_c_a1  <= r_b_a1;
            r_c_b1  <= r_b_b1;
            r_c_a2  <= r_b_a2;
            r_c_b2  <= r_b_b2;
            r_c_c1  <= C_W'(r_b_c1a) + C_W'(r_b_c1b);
            r_c_c2  <= C_W'(r_b_c2a) + C_W'(r_b_c2b);
            r_c_det <= DET_W'(r_b_d1) - DET_W'(r_b_d2);

            r_d_pt     <= r_c_pt;
            r_d_nx1    <= NP_W'(r_c_b2) * NP_W'(r_c_c1);
            r_d_nx2    <= NP_W'(r_c_b1) * NP_W'(r_c_c2);
            r_d_ny1    <= NP_W'(r_c_a1) * NP_W'(r_c_c2);
            r_d_ny2    <= NP_W'(r_c_a2) * NP_W'(r_c_c1);
            r_d_detneg <= r_c_det[DET_W-1];
            r_d_dmag   <= r_c_det[DET_W-1] ? DET_W'(-r_c_det) : DET_W'(r_c_det);
            // A zero determinant is parallel even with a zero threshold.
            r_d_par    <= (r_c_det == '0)
                          || ((r_c_det[DET_W-1] ? DET_W'(-r_c_det) : DET_W'(r_c_det))
                              < DET_W'(r_thr));

            r_e_pt     <= r_d_pt;
            r_e_numx   <= NUM_W'(r_d_nx1) - NUM_W'(r_d_nx2);
            r_e_numy   <= NUM_W'(r_d_ny1) - NUM_W'(r_d_ny2);
            r_e_detneg <= r_d_detneg;
            r_e_dmag   <= r_d_dmag;
            r_e_par    <= r_d_par;
        end
    end

    // Divider load: magnitudes scaled by the fraction bits, signs kept aside.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (adv) begin
            r_dv[0] <= r_ve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ds[0].pt   <= r_e_pt;
            r_ds[0].par  <= r_e_par;
            r_ds[0].dmag <= r_e_dmag;
            r_ds[0].negx <= r_e_numx[NUM_W-1] ^ r_e_detneg;
            r_ds[0].negy <= r_e_numy[NUM_W-1] ^ r_e_detneg;
            r_xrem[0]    <= '0;
            r_yrem[0]    <= '0;
            r_xw[0]      <= {(r_e_numx[NUM_W-1] ? NUM_W'(-r_e_numx) : NUM_W'(r_e_numx)),
                             {FRAC_BITS{1'b0}}};
            r_yw[0]      <= {(r_e_numy[NUM_W-1] ? NUM_W'(-r_e_numy) : NUM_W'(r_e_numy)),
                             {FRAC_BITS{1'b0}}};
        end
    end

    // One restoring step per stage for each coordinate.
    for (genvar k = 1; k <= QW; k++) begin : g_div
        logic [DET_W:0] xsh, ysh;
        logic           xge, yge;

        always_comb begin
            xsh = {r_xrem[k-1], r_xw[k-1][QW-1]};
            ysh = {r_yrem[k-1], r_yw[k-1][QW-1]};
            xge = xsh >= {1'b0, r_ds[k-1].dmag};
            yge = ysh >= {1'b0, r_ds[k-1].dmag};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k] <= 1'b0;
            end else if (adv) begin
                r_dv[k] <= r_dv[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_ds[k]   <= r_ds[k-1];
                r_xrem[k] <= xge ? DET_W'(xsh - {1'b0, r_ds[k-1].dmag}) : DET_W'(xsh);
                r_yrem[k] <= yge ? DET_W'(ysh - {1'b0, r_ds[k-1].dmag}) : DET_W'(ysh);
                r_xw[k]   <= {r_xw[k-1][QW-2:0], xge};
                r_yw[k]   <= {r_yw[k-1][QW-2:0], yge};
            end
        end
    end

    // Stage F: clip each quotient to the output range and apply the sign.
    logic [QW-1:0]       limx, limy;
    logic                satx, saty;
    logic [OUT_BITS-1:0] magx, magy;

    always_comb begin
        limx = QW'({1'b1, {(OUT_BITS-1){1'b0}}}) - QW'(!r_ds[QW].negx);
        limy = QW'({1'b1, {(OUT_BITS-1){1'b0}}}) - QW'(!r_ds[QW].negy);
        satx = r_xw[QW] > limx;
        saty = r_yw[QW] > limy;
        magx = satx ? limx[OUT_BITS-1:0] : r_xw[QW][OUT_BITS-1:0];
        magy = saty ? limy[OUT_BITS-1:0] : r_yw[QW][OUT_BITS-1:0];
    end

    // Back stages: valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
            r_vg <= 1'b0;
            r_vh <= 1'b0;
        end else if (adv) begin
            r_vf <= r_dv[QW];
            r_vg <= r_vf;
            r_vh <= r_vg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f_pt  <= r_ds[QW].pt;
            r_f_par <= r_ds[QW].par;
            r_f_x   <= r_ds[QW].negx ? OUT_BITS'(-magx) : magx;
            r_f_y   <= r_ds[QW].negy ? OUT_BITS'(-magy) : magy;
            r_f_sat <= satx | saty;

            // Stage G: the clipped point is the one checked against the boxes.
            r_g_cmd    <= r_f_pt.cmd;
            r_g_par    <= r_f_par;
            r_g_x      <= r_f_x;
            r_g_y      <= r_f_y;
            r_g_sat    <= r_f_sat;
            r_g_box[0] <= box_class(r_f_pt.first_start_x, r_f_pt.first_end_x, r_f_x);
            r_g_box[1] <= box_class(r_f_pt.first_start_y, r_f_pt.first_end_y, r_f_y);
            r_g_box[2] <= box_class(r_f_pt.second_start_x, r_f_pt.second_end_x, r_f_x);
            r_g_box[3] <= box_class(r_f_pt.second_start_y, r_f_pt.second_end_y, r_f_y);

            r_h_cmd <= r_g_cmd;
            r_h_par <= r_g_par;
            r_h_x   <= r_g_x;
            r_h_y   <= r_g_y;
            r_h_sat <= r_g_sat;
        end
    end

    // Stage H: one 32 by 32 product per box axis.
    for (genvar j = 0; j < 4; j++) begin : g_box
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_h_box[j].zero <= r_g_box[j].zero;
                r_h_box[j].opp  <= r_g_box[j].opp;
                r_h_box[j].big  <= r_g_box[j].big;
                r_h_box[j].prod <= (2*TOL_W)'(r_g_box[j].mu) * (2*TOL_W)'(r_g_box[j].mv);
            end
        end
    end

    // Final decision, formed from stage H.
    t_lsi_out n_res;
    logic     in_boxes;

    always_comb begin
        in_boxes = box_pass(r_h_box[0], r_tol) && box_pass(r_h_box[1], r_tol)
                   && box_pass(r_h_box[2], r_tol) && box_pass(r_h_box[3], r_tol);
        n_res  = '0;
        if (r_h_par) begin
            n_res.status = ST_PARALLEL;
        end else if (r_h_cmd && !in_boxes) begin
            n_res.status = ST_OUTSIDE;
        end else begin
            n_res.status    = ST_FOUND;
            n_res.cross_x   = r_h_x;
            n_res.cross_y   = r_h_y;
            n_res.saturated = r_h_sat;
        end
    end

    // Output register with a skid register behind it. A result that leaves
    // stage H while the output register is full and stalled waits in the skid
    // register, and the pipeline holds until it drains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || !i_stall) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= r_vh;
            end
        end else if (r_vh && adv) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || !i_stall) begin
            r_out <= r_skid_v ? r_skid : n_res;
        end else if (adv) begin
            r_skid <= n_res;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // The skid register only fills behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register holds a result while the output register is empty");

    // A held result stays held while the output is stalled.
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_stall) |=> (r_skid_v && r_out_v))
        else $error("buffered result lost under output stall");

    // Parallel and outside results carry an empty point.
    a_empty_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.status == ST_PARALLEL || o_data.status == ST_OUTSIDE))
        |-> (o_data.cross_x == '0 && o_data.cross_y == '0 && !o_data.saturated))
        else $error("non-empty point on a parallel or outside result");

    // Only the three status codes are ever produced.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.status == ST_FOUND || o_data.status == ST_PARALLEL
                     || o_data.status == ST_OUTSIDE))
        else $error("undefined status code on the output");

endmodule

[sim/lsi_checker.sv]
// Checker of the line segment intersection unit: it predicts every result and compares.
`timescale 1ns / 1ps

module lsi_checker
    import lsi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_in_stall,
    input  t_lsi_in              i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_stall,
    input  t_lsi_out             i_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef logic signed [127:0] t_wide;

    logic [THR_W-1:0] threshold_copy;
    logic [TOL_W-1:0] tolerance_copy;
    t_lsi_out         crossings_due[$];

    // Quotient in fixed point, truncated toward zero and clipped to the output range.
    function automatic logic signed [OUT_BITS-1:0] fixed_quotient(input t_wide num,
                                                                  input t_wide den,
                                                                  inout bit sat);
        bit           neg;
        logic [127:0] num_mag;
        logic [127:0] den_mag;
        logic [127:0] quo;
        logic [127:0] lim;
        neg     = (num < 0) != (den < 0);
        num_mag = (num < 0) ? -num : num;
        den_mag = (den < 0) ? -den : den;
        quo     = (num_mag << FRAC_BITS) / den_mag;
        lim     = neg ? (128'd1 << (OUT_BITS - 1)) : ((128'd1 << (OUT_BITS - 1)) - 1);
        if (quo > lim) begin
            sat = 1'b1;
            quo = lim;
        end
        if (neg) begin
            quo = -quo;
        end
        return quo[OUT_BITS-1:0];
    endfunction

    // One axis of one bounding box, with the configured slack.
    function automatic bit within_span(input t_wide a, input t_wide b, input t_wide p);
        t_wide prod;
        prod = (a * 65536 - p) * (p - b * 65536) + t_wide'({96'b0, tolerance_copy});
        return prod > 0;
    endfunction

    function automatic t_lsi_out crossing_of(input t_lsi_in d);
        t_lsi_out r;
        t_wide    p1x, p1y, q1x, q1y, p2x, p2y, q2x, q2y;
        t_wide    a1, b1, c1, a2, b2, c2, det, det_mag, px, py;
        bit       sat;
        logic signed [OUT_BITS-1:0] qx;
        logic signed [OUT_BITS-1:0] qy;
        r   = '0;
        sat = 1'b0;
        p1x = d.first_start_x;  p1y = d.first_start_y;
        q1x = d.first_end_x;    q1y = d.first_end_y;
        p2x = d.second_start_x; p2y = d.second_start_y;
        q2x = d.second_end_x;   q2y = d.second_end_y;
        a1  = q1y - p1y;  b1 = p1x - q1x;  c1 = a1 * p1x + b1 * p1y;
        a2  = q2y - p2y;  b2 = p2x - q2x;  c2 = a2 * p2x + b2 * p2y;
        det = a1 * b2 - a2 * b1;
        det_mag = (det < 0) ? -det : det;
        if (det == 0 || det_mag < t_wide'({112'b0, threshold_copy})) begin
            r.status = ST_PARALLEL;
            return r;
        end
        qx = fixed_quotient(b2 * c1 - b1 * c2, det, sat);
        qy = fixed_quotient(a1 * c2 - a2 * c1, det, sat);
        px = qx;
        py = qy;
        if (d.cmd && !(within_span(p1x, q1x, px) && within_span(p1y, q1y, py) &&
                       within_span(p2x, q2x, px) && within_span(p2y, q2y, py))) begin
            r.status = ST_OUTSIDE;
            return r;
        end
        r.status    = ST_FOUND;
        r.cross_x   = qx;
        r.cross_y   = qy;
        r.saturated = sat;
        return r;
    endfunction

    assign o_pending = crossings_due.size();

    always @(posedge i_clk) begin
        t_lsi_out want;
        if (!i_rst_n) begin
            threshold_copy = 16'd1;
            tolerance_copy = 32'd1;
            o_fail_count   = 0;
            crossings_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_THRESHOLD) begin
                    threshold_copy = i_cfg_data[THR_W-1:0];
                end else begin
                    tolerance_copy = i_cfg_data[TOL_W-1:0];
                end
            end
            if (i_out_valid && !i_stall) begin
                if (crossings_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("unexpected result transfer: %h", i_out_data);
                    end
                end else begin
                    want = crossings_due.pop_front();
                    if (want.status !== i_out_data.status ||
                        want.cross_x !== i_out_data.cross_x ||
                        want.cross_y !== i_out_data.cross_y ||
                        want.saturated !== i_out_data.saturated) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("mismatch: expected st=%0d x=%h y=%h sat=%0b",
                                     want.status, want.cross_x, want.cross_y,
                                     want.saturated);
                            $display("          actual   st=%0d x=%h y=%h sat=%0b",
                                     i_out_data.status, i_out_data.cross_x,
                                     i_out_data.cross_y, i_out_data.saturated);
                        end
                    end
                end
            end
            if (i_valid && !i_in_stall) begin
                crossings_due.push_back(crossing_of(i_in_data));
            end
        end
    end

endmodule

[sim/testbench.sv]
// Top of the testbench: clock, reset, stimulus, receiver stalls and the verdict.
`timescale 1ns / 1ps

module testbench;
    import lsi_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    t_lsi_in              i_data;
    logic                 o_valid;
    logic                 i_stall;
    t_lsi_out             o_data;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    int                   fail_count;
    int                   pending;
    bit                   long_hold;

    line_segment_intersection uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    lsi_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_in_stall(o_stall), .i_in_data(i_data),
        .i_out_valid(o_valid), .i_stall(i_stall), .i_out_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // The run is cut off after a generous fixed time in case a handshake hangs.
    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(10, 40);
        end
        if ($urandom_range(0, 2) == 0) begin
            return $urandom_range(1, 3);
        end
        return 0;
    endfunction

    // The receiver stalls at random. When the stimulus asks for it, it holds off
    // for a long stretch counted here, so the pipeline fills and stalls its input.
    initial begin
        int hold;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_stall = 1'b1;
                repeat (300) @(negedge i_clk);
                long_hold = 1'b0;
            end
            hold = gap_length();
            i_stall = (hold != 0);
            repeat (hold > 0 ? hold - 1 : 0) @(negedge i_clk);
        end
    end

    // Offers one item at a falling edge and keeps it steady until a transfer.
    // o_stall is a register output, so its value at the falling edge is the one
    // that the next rising edge sees.
    task automatic offer_pair(input t_lsi_in d);
        bit stalled;
        i_valid = 1'b1;
        i_data  = d;
        do begin
            stalled = o_stall;
            @(negedge i_clk);
        end while (stalled);
    endtask

    task automatic offer_with_gap(input t_lsi_in d, input bit no_gap);
        int g;
        g = no_gap ? 0 : gap_length();
        if (g > 0) begin
            i_valid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        offer_pair(d);
    endtask

    function automatic t_lsi_in make_pair(input bit cmd, input int x1, input int y1,
                                          input int x2, input int y2, input int x3,
                                          input int y3, input int x4, input int y4);
        t_lsi_in d;
        d.cmd = cmd;
        d.first_start_x  = x1[15:0]; d.first_start_y  = y1[15:0];
        d.first_end_x    = x2[15:0]; d.first_end_y    = y2[15:0];
        d.second_start_x = x3[15:0]; d.second_start_y = y3[15:0];
        d.second_end_x   = x4[15:0]; d.second_end_y   = y4[15:0];
        return d;
    endfunction

    function automatic int near_coord(input int c, input int span);
        int v;
        v = c + $urandom_range(0, 2 * span) - span;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    // Random pairs of several shapes: fully random words, extremes, crossing
    // segments around a common point, exact parallels and near parallels.
    function automatic t_lsi_in random_pair();
        t_lsi_in      d;
        logic [159:0] raw;
        int           cx, cy, dx, dy, ex, ey, s;
        raw   = {$urandom, $urandom, $urandom, $urandom, $urandom};
        d     = raw[$bits(t_lsi_in)-1:0];
        d.cmd = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0: begin
                raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
                d   = raw[$bits(t_lsi_in)-1:0];
            end
            1: begin
                d.first_start_x  = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                d.first_end_y    = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                d.second_start_y = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                d.second_end_x   = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            end
            2, 3: begin
                s  = $urandom_range(0, 1) ? 40 : 20000;
                cx = near_coord(0, 30000);
                cy = near_coord(0, 30000);
                dx = $urandom_range(0, s) - s / 2;
                dy = $urandom_range(0, s) - s / 2;
                ex = $urandom_range(0, s) - s / 2;
                ey = $urandom_range(0, s) - s / 2;
                d  = make_pair(1'($urandom_range(0, 1)),
                               near_coord(cx, 2) - dx, near_coord(cy, 2) - dy,
                               near_coord(cx, 2) + dx, near_coord(cy, 2) + dy,
                               near_coord(cx, 2) - ex, near_coord(cy, 2) - ey,
                               near_coord(cx, 2) + ex, near_coord(cy, 2) + ey);
            end
            4: begin
                dx = $urandom_range(0, 2000) - 1000;
                dy = $urandom_range(0, 2000) - 1000;
                cx = near_coord(0, 20000);
                cy = near_coord(0, 20000);
                ex = $urandom_range(0, 400) - 200;
                ey = $urandom_range(0, 400) - 200;
                d  = make_pair(1'($urandom_range(0, 1)), cx, cy, cx + dx, cy + dy,
                               cx + ex, cy + ey, cx + ex + dx, cy + ey + dy);
            end
            default: begin
                cx = near_coord(0, 30000);
                cy = near_coord(0, 30000);
                d  = make_pair(1'($urandom_range(0, 1)), cx, cy, near_coord(cx, 3),
                               near_coord(cy, 3), near_coord(cx, 3), near_coord(cy, 3),
                               near_coord(cx, 3), near_coord(cy, 3));
            end
        endcase
        return d;
    endfunction

    // Waits for every expected result and for the pipeline depth on top of it,
    // then writes one register at a falling edge.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_valid = 1'b0;
        wait (pending == 0);
        repeat (100) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    initial begin
        logic [31:0] thresholds[5];
        logic [31:0] tolerances[5];
        int          ph;
        int          n;
        int          drain;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_data     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_THRESHOLD;
        i_cfg_data = '0;
        long_hold  = 1'b0;
        thresholds = '{32'd1, 32'd0, 32'd65535, 32'd1000, 32'd3};
        tolerances = '{32'd1, 32'd0, 32'hffffffff, 32'd65536, 32'h40000000};
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed pairs under the reset settings: degenerate, extremes, a plain
        // crossing in both modes, a fractional crossing, parallel and collinear
        // lines, touching endpoints and a point outside.
        offer_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0));
        offer_pair(make_pair(1, -10, 0, 10, 0, 0, -10, 0, 10));
        offer_pair(make_pair(0, -10, 0, 10, 0, 0, -10, 0, 10));
        offer_pair(make_pair(1, 0, 0, 3, 1, 0, 1, 1, 0));
        offer_pair(make_pair(0, 0, 0, 5, 5, 0, 1, 5, 6));
        offer_pair(make_pair(1, 0, 0, 5, 5, 1, 1, 7, 7));
        offer_pair(make_pair(1, 0, 0, 10, 0, 10, 0, 10, 10));
        offer_pair(make_pair(1, 0, 0, 10, 0, 20, -5, 20, 5));
        offer_pair(make_pair(0, 0, 0, 10, 0, 20, -5, 20, 5));
        offer_pair(make_pair(0, -32768, -32768, 32767, 32767, -32768, 32767,
                             32767, -32768));
        offer_pair(make_pair(1, -32768, -32768, 32767, 32767, -32768, 32767,
                             32767, -32768));
        offer_pair(make_pair(0, -32768, 32767, 32767, 32766, -32768, 32766,
                             32767, 32766));
        offer_pair(make_pair(0, 32767, -32768, -32768, 32767, 32767, -32767,
                             -32767, 32767));
        offer_pair(make_pair(1, 32767, -32768, -32768, 32767, 32767, -32767,
                             -32767, 32767));
        offer_pair(make_pair(0, 0, 0, 32767, 1, 0, 1, 32767, 2));
        offer_pair(make_pair(0, -32768, -32768, -32768, -32768, 32767, 32767,
                             32767, 32767));
        offer_pair(make_pair(1, -7, -3, 9, 11, 5, -13, -4, 8));

        // Several register settings, the extremes among them, each followed by
        // random pairs. The first phase also holds the long receiver stall with
        // a burst longer than the pipeline holds, and a pause of the sender until
        // the pipeline has drained.
        for (ph = 0; ph < 5; ph++) begin
            write_register(CFG_THRESHOLD, thresholds[ph]);
            write_register(CFG_TOLERANCE, tolerances[ph]);
            for (n = 0; n < 100; n++) begin
                if (ph == 0 && n == 5) begin
                    long_hold = 1'b1;
                end
                if (ph == 0 && n == 95) begin
                    i_valid = 1'b0;
                    wait (pending == 0);
                    @(negedge i_clk);
                end
                offer_with_gap(random_pair(), ph == 0 && n >= 5 && n < 95);
            end
        end
        i_valid = 1'b0;

        // Drain what is left, then allow the pipeline depth once more.
        drain = 0;
        while (pending != 0 && drain < 20000) begin
            @(negedge i_clk);
            drain++;
        end
        repeat (100) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
